// File: hdl/pta_pkg.sv
// Package for the barometric altitude unit: word types, layer codes and
// fixed-point constants. No dependencies.
package pta_pkg;

   localparam int PRESS_W = 24;
   localparam int ALT_W   = 22;
   localparam int LG_W    = 29;   // unsigned Q24 log2 of a 24-bit value
   localparam int D_W     = 30;   // signed Q24 log ratio
   localparam int FRAC_W  = 24;
   localparam int STEPS   = 24;

   localparam logic [1:0] LAYER_TROPO = 2'd0;
   localparam logic [1:0] LAYER_LOWER = 2'd1;
   localparam logic [1:0] LAYER_UPPER = 2'd2;

   localparam logic [PRESS_W-1:0] SEA_LEVEL_Q6  = 24'd6484800;
   localparam logic [PRESS_W-1:0] TROPOPAUSE_Q6 = 24'd1448320;
   localparam logic [PRESS_W-1:0] MID_STRAT_Q6  = 24'd350400;

   localparam logic [27:0] EXP_TROPO_Q30 = 28'd204297034;
   localparam logic [27:0] EXP_UPPER_Q30 = 28'd31430313;
   localparam logic [24:0] K_TROPO = 25'd11348677;
   localparam logic [24:0] K_LOWER = 25'd18004992;
   localparam logic [24:0] K_UPPER = 25'd3466400;

   localparam logic signed [ALT_W-1:0] ALT_MIN_Q4 = -22'sd131072;
   localparam logic signed [ALT_W-1:0] ALT_MAX_Q4 = 22'sd2097151;
   localparam logic signed [31:0] BASE_LOWER = 32'sd176000;
   localparam logic signed [31:0] BASE_UPPER = 32'sd320000;

   typedef struct packed {
      logic       valid;
      logic [1:0] layer;
      logic       invalid;
   } ctl_type;

   // log2 in Q24 by repeated squaring, evaluated at elaboration for the
   // reference pressures
   function automatic logic [LG_W-1:0] lg2_q24(input logic [PRESS_W-1:0] v);
      logic [4:0]  top;
      logic [63:0] m;
      logic [FRAC_W-1:0] bits;
      top  = '0;
      bits = '0;
      for (int i = 0; i < PRESS_W; i++) begin
         if (v[i]) top = 5'(i);
      end
      m = 64'(v) << (30 - top);
      for (int i = 0; i < STEPS; i++) begin
         m = (m * m) >> 30;
         bits = {bits[FRAC_W-2:0], m[31]};
         if (m[31]) m = m >> 1;
      end
      return {top, bits};
   endfunction

   localparam logic [LG_W-1:0] LG_SEA   = lg2_q24(SEA_LEVEL_Q6);
   localparam logic [LG_W-1:0] LG_TROPO = lg2_q24(TROPOPAUSE_Q6);
   localparam logic [LG_W-1:0] LG_MID   = lg2_q24(MID_STRAT_Q6);

   // 2^(2^-(k+1)) in Q30
   function automatic logic [30:0] pow2_step(input logic [4:0] k);
      logic [30:0] s;
      case (k)
         5'd0:  s = 31'd1518500250;
         5'd1:  s = 31'd1276901417;
         5'd2:  s = 31'd1170923762;
         5'd3:  s = 31'd1121280436;
         5'd4:  s = 31'd1097253708;
         5'd5:  s = 31'd1085434106;
         5'd6:  s = 31'd1079572136;
         5'd7:  s = 31'd1076653033;
         5'd8:  s = 31'd1075196443;
         5'd9:  s = 31'd1074468888;
         5'd10: s = 31'd1074105294;
         5'd11: s = 31'd1073923544;
         5'd12: s = 31'd1073832680;
         5'd13: s = 31'd1073787251;
         5'd14: s = 31'd1073764537;
         5'd15: s = 31'd1073753181;
         5'd16: s = 31'd1073747502;
         5'd17: s = 31'd1073744663;
         5'd18: s = 31'd1073743244;
         5'd19: s = 31'd1073742534;
         5'd20: s = 31'd1073742179;
         5'd21: s = 31'd1073742001;
         5'd22: s = 31'd1073741913;
         5'd23: s = 31'd1073741868;
         default: s = 31'd1073741824;
      endcase
      return s;
   endfunction

endpackage

// File: hdl/pta_if.sv
// Handshake channels for the altitude unit: pressure request and altitude
// response. Depends on pta_pkg.
interface pta_req_if import pta_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PRESS_W-1:0] pressure_q6;
   modport source (output valid, output pressure_q6, input ready);
   modport sink   (input valid, input pressure_q6, output ready);
endinterface

interface pta_rsp_if import pta_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [ALT_W-1:0] altitude_q4;
   logic [1:0]              layer;
   logic                    pressure_invalid;
   modport source (output valid, output altitude_q4, output layer,
                   output pressure_invalid, input ready);
   modport sink   (input valid, input altitude_q4, input layer,
                   input pressure_invalid, output ready);
endinterface

// File: hdl/pressure_to_altitude_isa_unit.sv
// Barometric altitude unit, top level: log2 pipe, exponent, pow2 pipe and
// final scaling. Depends on pta_pkg, pta_if, pta_log2_pipe, pta_pow2_pipe.
//
// Takes one pressure word per cycle and returns altitude after the standard
// atmosphere. The two 24-stage squaring and table-multiply chains, one
// 32-bit multiplier per stage, make up most of the pipeline.
// The whole pipeline holds while a finished word waits on a stalled
// response; otherwise a new word is taken in every cycle. No reset sweep.
module pressure_to_altitude_isa_unit import pta_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   pta_req_if.sink      req,
   pta_rsp_if.source    rsp
);

   logic    adv;
   logic    rsp_valid_ff;
   ctl_type in_ctl;
   ctl_type lg_ctl;
   logic [LG_W-1:0] lg2;

   // advance while the response register is free or being taken
   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   // pick the layer on the raw word
   always_comb begin
      in_ctl.valid   = req.valid;
      in_ctl.invalid = (req.pressure_q6 == '0);
      if (req.pressure_q6 > TROPOPAUSE_Q6) begin
         in_ctl.layer = LAYER_TROPO;
      end else if (req.pressure_q6 > MID_STRAT_Q6) begin
         in_ctl.layer = LAYER_LOWER;
      end else begin
         in_ctl.layer = LAYER_UPPER;
      end
   end

   pta_log2_pipe u_log2 (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_ctl  (in_ctl),
      .in_x    (req.pressure_q6),
      .out_ctl (lg_ctl),
      .out_lg2 (lg2)
   );

   // log ratio against the layer's reference
   ctl_type               d_ctl_ff;
   logic signed [D_W-1:0] d_ff, d_in;
   always_comb begin
      case (lg_ctl.layer)
         LAYER_TROPO: d_in = $signed({1'b0, lg2}) - $signed({1'b0, LG_SEA});
         LAYER_LOWER: d_in = $signed({1'b0, lg2}) - $signed({1'b0, LG_TROPO});
         default:     d_in = $signed({1'b0, LG_MID}) - $signed({1'b0, lg2});
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ctl_ff <= '0;
      end else if (adv) begin
         d_ctl_ff <= lg_ctl;
      end
      if (adv) begin
         d_ff <= d_in;
      end
   end

   // exponent product: |d| times the layer exponent
   ctl_type               tm_ctl_ff;
   logic [56:0]           tm_prod_ff, tm_prod_in;
   logic                  tm_neg_ff;
   logic signed [D_W-1:0] tm_d_ff;
   logic [D_W-2:0]        d_mag;
   logic [27:0]           exp_k;
   assign d_mag = d_ff[D_W-1] ? (D_W-1)'(-d_ff) : d_ff[D_W-2:0];
   assign exp_k = (d_ctl_ff.layer == LAYER_UPPER) ? EXP_UPPER_Q30 : EXP_TROPO_Q30;
   assign tm_prod_in = d_mag * exp_k;

   always_ff @(posedge clock) begin
      if (reset) begin
         tm_ctl_ff <= '0;
      end else if (adv) begin
         tm_ctl_ff <= d_ctl_ff;
      end
      if (adv) begin
         tm_prod_ff <= tm_prod_in;
         tm_neg_ff  <= d_ff[D_W-1];
         tm_d_ff    <= d_ff;
      end
   end

   // round the exponent to Q24, half away from zero
   ctl_type               t_ctl_ff;
   logic signed [D_W-1:0] t_ff, t_in, t_d_ff;
   logic [57:0]           t_rnd;
   logic [D_W-1:0]        t_mag;
   assign t_rnd = 58'(tm_prod_ff) + (58'd1 << 29);
   assign t_mag = D_W'(t_rnd >> 30);
   assign t_in  = tm_neg_ff ? -$signed(t_mag) : $signed(t_mag);

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ctl_ff <= '0;
      end else if (adv) begin
         t_ctl_ff <= tm_ctl_ff;
      end
      if (adv) begin
         t_ff   <= t_in;
         t_d_ff <= tm_d_ff;
      end
   end

   ctl_type               p_ctl;
   logic [31:0]           p_r;
   logic signed [D_W-1:0] p_d;

   pta_pow2_pipe u_pow2 (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_ctl  (t_ctl_ff),
      .in_t    (t_ff),
      .in_d    (t_d_ff),
      .out_ctl (p_ctl),
      .out_r   (p_r),
      .out_d   (p_d)
   );

   // pick the scaling operand and take its magnitude
   ctl_type           a_ctl_ff;
   logic [31:0]       a_mag_ff, a_mag_in;
   logic              a_neg_ff, a_neg_in;
   logic signed [32:0] r_off;
   assign r_off = $signed({1'b0, p_r}) - (33'sd1 <<< 30);
   always_comb begin
      if (p_ctl.layer == LAYER_LOWER) begin
         a_neg_in = p_d[D_W-1];
         a_mag_in = a_neg_in ? 32'(-p_d) : 32'(p_d);
      end else begin
         a_neg_in = r_off[32];
         a_mag_in = a_neg_in ? 32'(-r_off) : r_off[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
      end else if (adv) begin
         a_ctl_ff <= p_ctl;
      end
      if (adv) begin
         a_mag_ff <= a_mag_in;
         a_neg_ff <= a_neg_in;
      end
   end

   // scale by the layer constant
   ctl_type     h_ctl_ff;
   logic [56:0] h_prod_ff;
   logic        h_neg_ff;
   logic [24:0] scale_k;
   always_comb begin
      case (a_ctl_ff.layer)
         LAYER_TROPO: scale_k = K_TROPO;
         LAYER_LOWER: scale_k = K_LOWER;
         default:     scale_k = K_UPPER;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ctl_ff <= '0;
      end else if (adv) begin
         h_ctl_ff <= a_ctl_ff;
      end
      if (adv) begin
         h_prod_ff <= a_mag_ff * scale_k;
         h_neg_ff  <= a_neg_ff;
      end
   end

   // round, add the layer base and saturate; an invalid word reads full scale
   logic [57:0]        h_rnd;
   logic [27:0]        h_mag;
   logic signed [31:0] h_sv, h_val;
   logic signed [ALT_W-1:0] alt_in;
   always_comb begin
      case (h_ctl_ff.layer)
         LAYER_TROPO: begin
            h_rnd = 58'(h_prod_ff) + (58'd1 << 33);
            h_mag = 28'(h_rnd >> 34);
         end
         LAYER_LOWER: begin
            h_rnd = 58'(h_prod_ff) + (58'd1 << 31);
            h_mag = 28'(h_rnd >> 32);
         end
         default: begin
            h_rnd = 58'(h_prod_ff) + (58'd1 << 29);
            h_mag = 28'(h_rnd >> 30);
         end
      endcase
      h_sv = h_neg_ff ? -$signed({4'd0, h_mag}) : $signed({4'd0, h_mag});
      case (h_ctl_ff.layer)
         LAYER_TROPO: h_val = -h_sv;
         LAYER_LOWER: h_val = BASE_LOWER - h_sv;
         default:     h_val = BASE_UPPER + h_sv;
      endcase
      if (h_ctl_ff.invalid) begin
         alt_in = ALT_MAX_Q4;
      end else if (h_val < 32'(ALT_MIN_Q4)) begin
         alt_in = ALT_MIN_Q4;
      end else if (h_val > 32'(ALT_MAX_Q4)) begin
         alt_in = ALT_MAX_Q4;
      end else begin
         alt_in = h_val[ALT_W-1:0];
      end
   end

   // response register
   logic signed [ALT_W-1:0] alt_ff;
   logic [1:0]              layer_ff;
   logic                    inv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= h_ctl_ff.valid;
      end
      if (adv) begin
         alt_ff   <= alt_in;
         layer_ff <= h_ctl_ff.layer;
         inv_ff   <= h_ctl_ff.invalid;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.altitude_q4      = alt_ff;
   assign rsp.layer            = layer_ff;
   assign rsp.pressure_invalid = inv_ff;

   // zero pressure always reports the top layer at full scale
   a_invalid_word: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.pressure_invalid |->
         rsp.layer == LAYER_UPPER && rsp.altitude_q4 == ALT_MAX_Q4)
      else $error("invalid word with wrong layer or altitude");

   // upper stratosphere never reads below its base altitude
   a_upper_floor: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.pressure_invalid && rsp.layer == LAYER_UPPER |->
         rsp.altitude_q4 >= 22'sd320000)
      else $error("upper layer altitude below base");

   // a held response keeps the pipeline frozen
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(h_ctl_ff) && $stable(alt_ff))
      else $error("pipeline moved during stall");

endmodule

// File: hdl/pta_log2_pipe.sv
// Pipelined log2 of a 24-bit sample in Q24: normalise, then one squaring
// per stage. Depends on pta_pkg.
module pta_log2_pipe import pta_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  ctl_type            in_ctl,
   input  logic [PRESS_W-1:0] in_x,
   output ctl_type            out_ctl,
   output logic [LG_W-1:0]    out_lg2
);

   ctl_type           ctl_ff  [0:STEPS];
   logic [4:0]        top_ff  [0:STEPS];
   logic [30:0]       m_ff    [0:STEPS];
   logic [FRAC_W-1:0] frac_ff [0:STEPS];

   logic [4:0]  top_in;
   logic [30:0] m_in;

   // find the leading one and normalise the mantissa to Q30
   always_comb begin
      top_in = '0;
      for (int i = 0; i < PRESS_W; i++) begin
         if (in_x[i]) top_in = 5'(i);
      end
      m_in = 31'(31'(in_x) << (5'd30 - top_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (adv) begin
         ctl_ff[0] <= in_ctl;
      end
      if (adv) begin
         top_ff[0]  <= top_in;
         m_ff[0]    <= m_in;
         frac_ff[0] <= '0;
      end
   end

   // one squaring per stage, shift in a fraction bit
   for (genvar s = 1; s <= STEPS; s++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] hi;
      assign sq = m_ff[s-1] * m_ff[s-1];
      assign hi = sq[61:30];

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else if (adv) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
         if (adv) begin
            top_ff[s]  <= top_ff[s-1];
            m_ff[s]    <= hi[31] ? hi[31:1] : hi[30:0];
            frac_ff[s] <= {frac_ff[s-1][FRAC_W-2:0], hi[31]};
         end
      end
   end

   assign out_ctl = ctl_ff[STEPS];
   assign out_lg2 = {top_ff[STEPS], frac_ff[STEPS]};

endmodule

// File: hdl/pta_pow2_pipe.sv
// Pipelined 2^t for t in Q24 within [-1, 1): one table multiply per
// fraction bit, then the floor shift. Depends on pta_pkg.
module pta_pow2_pipe import pta_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  ctl_type               in_ctl,
   input  logic signed [D_W-1:0] in_t,
   input  logic signed [D_W-1:0] in_d,
   output ctl_type               out_ctl,
   output logic [31:0]           out_r,
   output logic signed [D_W-1:0] out_d
);

   ctl_type               ctl_ff  [1:STEPS];
   logic [31:0]           r_ff    [1:STEPS];
   logic [FRAC_W-1:0]     frac_ff [1:STEPS];
   logic                  neg_ff  [1:STEPS];
   logic signed [D_W-1:0] d_ff    [1:STEPS];

   for (genvar k = 1; k <= STEPS; k++) begin : g_mul
      ctl_type               prev_ctl;
      logic [31:0]           prev_r;
      logic [FRAC_W-1:0]     prev_frac;
      logic                  prev_neg;
      logic signed [D_W-1:0] prev_d;
      logic [62:0]           prod;

      // stage one reads the unregistered entry point
      if (k == 1) begin : g_head
         assign prev_ctl  = in_ctl;
         assign prev_r    = 32'd1 << 30;
         assign prev_frac = in_t[FRAC_W-1:0];
         assign prev_neg  = in_t[D_W-1];
         assign prev_d    = in_d;
      end else begin : g_tail
         assign prev_ctl  = ctl_ff[k-1];
         assign prev_r    = r_ff[k-1];
         assign prev_frac = frac_ff[k-1];
         assign prev_neg  = neg_ff[k-1];
         assign prev_d    = d_ff[k-1];
      end

      assign prod = prev_r * pow2_step(5'(k - 1)) + (63'd1 << 29);

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (adv) begin
            ctl_ff[k] <= prev_ctl;
         end
         if (adv) begin
            r_ff[k]    <= prev_frac[FRAC_W-k] ? prod[61:30] : prev_r;
            frac_ff[k] <= prev_frac;
            neg_ff[k]  <= prev_neg;
            d_ff[k]    <= prev_d;
         end
      end
   end

   // negative exponent has floor of minus one: halve, truncating
   assign out_ctl = ctl_ff[STEPS];
   assign out_r   = neg_ff[STEPS] ? (r_ff[STEPS] >> 1) : r_ff[STEPS];
   assign out_d   = d_ff[STEPS];

endmodule

// File: tb/pta_tb_pkg.sv
// Prediction helpers for the altitude unit testbench: fixed-point log2, pow2
// and the per-layer altitude formulae. Depends on pta_pkg.
package pta_tb_pkg;
   import pta_pkg::*;

   typedef struct packed {
      logic signed [ALT_W-1:0] altitude_q4;
      logic [1:0]              layer;
      logic                    pressure_invalid;
   } altitude_word_type;

   // 2^(2^-k) in Q30, k = 1..24
   localparam longint unsigned ROOT_STEPS [24] = '{
      1518500250, 1276901417, 1170923762, 1121280436, 1097253708,
      1085434106, 1079572136, 1076653033, 1075196443, 1074468888,
      1074105294, 1073923544, 1073832680, 1073787251, 1073764537,
      1073753181, 1073747502, 1073744663, 1073743244, 1073742534,
      1073742179, 1073742001, 1073741913, 1073741868};

   // log2 of a 24-bit word in unsigned Q24, squaring the Q30 mantissa
   function automatic longint log2_fixed(input logic [23:0] v);
      int top;
      longint unsigned m;
      longint unsigned frac;
      top  = 0;
      frac = 0;
      for (int i = 0; i < 24; i++) if (v[i]) top = i;
      m = longint'(v) << (30 - top);
      for (int i = 0; i < 24; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      return (longint'(top) << 24) | longint'(frac);
   endfunction

   // round(a * k / 2^s), half away from zero
   function automatic longint scale_round(input longint a, input longint unsigned k,
                                          input int s);
      longint unsigned mag;
      mag = (a < 0) ? longint'(-a) : longint'(a);
      mag = (mag * k + (64'd1 << (s - 1))) >> s;
      return (a < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   // 2^t for t in Q24, result in Q30
   function automatic longint exp2_fixed(input longint t);
      longint whole;
      longint unsigned frac;
      longint unsigned r;
      r = 64'd1 << 30;
      if (t < -(64'sd8 <<< 24)) t = -(64'sd8 <<< 24);
      if (t > (64'sd8 <<< 24) - 1) t = (64'sd8 <<< 24) - 1;
      if (t >= 0) whole = t >>> 24;
      else whole = -((-t + 64'hFFFFFF) >>> 24);
      frac = longint'(t - whole * (64'sd1 <<< 24)) & 64'hFFFFFF;
      for (int k = 1; k <= 24; k++) begin
         if (frac[24-k]) r = (r * ROOT_STEPS[k-1] + (64'd1 << 29)) >> 30;
      end
      if (whole >= 0) r = r << whole;
      else r = r >> (-whole);
      return longint'(r);
   endfunction

   function automatic altitude_word_type predict_altitude(input logic [23:0] p);
      altitude_word_type w;
      longint h, d, t;
      w.pressure_invalid = 1'b0;
      if (p == 0) begin
         w.altitude_q4      = ALT_MAX_Q4;
         w.layer            = LAYER_UPPER;
         w.pressure_invalid = 1'b1;
         return w;
      end
      if (p > TROPOPAUSE_Q6) begin
         w.layer = LAYER_TROPO;
         d = log2_fixed(p) - log2_fixed(SEA_LEVEL_Q6);
         t = scale_round(d, EXP_TROPO_Q30, 30);
         h = -scale_round(exp2_fixed(t) - (64'sd1 <<< 30), K_TROPO, 34);
      end else if (p > MID_STRAT_Q6) begin
         w.layer = LAYER_LOWER;
         d = log2_fixed(p) - log2_fixed(TROPOPAUSE_Q6);
         h = 176000 - scale_round(d, K_LOWER, 32);
      end else begin
         w.layer = LAYER_UPPER;
         d = log2_fixed(MID_STRAT_Q6) - log2_fixed(p);
         t = scale_round(d, EXP_UPPER_Q30, 30);
         h = 320000 + scale_round(exp2_fixed(t) - (64'sd1 <<< 30), K_UPPER, 30);
      end
      // saturate to the output range
      if (h < -131072) h = -131072;
      if (h > 2097151) h = 2097151;
      w.altitude_q4 = h[ALT_W-1:0];
      return w;
   endfunction
endpackage

// File: tb/pressure_to_altitude_isa_unit_test.sv
// Testbench for pressure_to_altitude_isa_unit: directed and random pressure
// words, random idling on both sides. Depends on pta_pkg, pta_if, pta_tb_pkg.
module pressure_to_altitude_isa_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pta_pkg::*;
   import pta_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   hold_off_cycles = 0;
   int   fail_count = 0;
   int   words_sent = 0;
   int   words_checked = 0;
   int   layer_seen [3] = '{0, 0, 0};
   altitude_word_type altitude_queue [$];

   pta_req_if req ();
   pta_rsp_if rsp ();

   pressure_to_altitude_isa_unit dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always #2 clock = ~clock;

   initial begin
      req.valid       = 1'b0;
      req.pressure_q6 = '0;
      rsp.ready       = 1'b0;
   end

   // drive receiver ready; a pending hold-off keeps it low
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp.ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // check each accepted altitude word against the oldest prediction
   always @(posedge clock) begin
      altitude_word_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (altitude_queue.size() == 0) begin
            $display("%0t: unexpected word alt=%0d layer=%0d inv=%0b", $time,
                     rsp.altitude_q4, rsp.layer, rsp.pressure_invalid);
            fail_count++;
         end else begin
            want = altitude_queue.pop_front();
            words_checked++;
            if (want.altitude_q4 !== rsp.altitude_q4 || want.layer !== rsp.layer ||
                want.pressure_invalid !== rsp.pressure_invalid) begin
               $display("%0t: mismatch exp alt=%0d lay=%0d inv=%0b got alt=%0d lay=%0d inv=%0b",
                        $time, want.altitude_q4, want.layer, want.pressure_invalid,
                        rsp.altitude_q4, rsp.layer, rsp.pressure_invalid);
               fail_count++;
            end
         end
      end
   end

   // withdraw the request while the sender idles
   task automatic drop_request();
      req.valid <= 1'b0;
   endtask

   // offer one pressure word, hold until accepted
   task automatic send_pressure(input logic [23:0] p);
      altitude_word_type w;
      while ($urandom_range(99) < send_idle_pct) begin
         drop_request();
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.pressure_q6 <= p;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      w = predict_altitude(p);
      altitude_queue.push_back(w);
      layer_seen[w.layer]++;
      words_sent++;
   endtask

   task automatic test_directed();
      logic [23:0] edges [$];
      edges = '{24'd0, 24'd1, 24'd2, 24'hFFFFFF, 24'h800000, 24'h7FFFFF,
                SEA_LEVEL_Q6, TROPOPAUSE_Q6, TROPOPAUSE_Q6 + 1, TROPOPAUSE_Q6 - 1,
                MID_STRAT_Q6, MID_STRAT_Q6 + 1, MID_STRAT_Q6 - 1, 24'd64,
                24'hAAAAAA, 24'h555555, 24'd10000000};
      foreach (edges[i]) send_pressure(edges[i]);
   endtask

   // mostly realistic pressures per layer, some full-range noise
   task automatic test_random(input int count);
      logic [23:0] p;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(4))
            0: p = 24'($urandom_range(24'hFFFFFF, TROPOPAUSE_Q6 + 1));
            1: p = 24'($urandom_range(TROPOPAUSE_Q6, MID_STRAT_Q6 + 1));
            2: p = 24'($urandom_range(MID_STRAT_Q6, 1));
            3: p = 24'($urandom_range(255));
            default: p = 24'($urandom);
         endcase
         send_pressure(p);
      end
   endtask

   // hold the receiver off long enough for the pipe to fill and stall input
   task automatic test_back_pressure();
      drop_request();
      @(posedge clock);
      hold_off_cycles <= 200;
      test_random(100);
   endtask

   task automatic wait_drained();
      drop_request();
      while (altitude_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 37;
      recv_idle_pct = 60;
      test_directed();
      test_random(150);
      send_idle_pct = 60;
      recv_idle_pct = 37;
      test_random(150);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_back_pressure();
      test_random(150);
      wait_drained();
      $display("Covered %0d pressure words, %0d checked; layers tropo/lower/upper: %0d/%0d/%0d",
               words_sent, words_checked, layer_seen[0], layer_seen[1], layer_seen[2]);
      if (fail_count == 0 && altitude_queue.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// File: filelist.f
hdl/pta_pkg.sv
hdl/pta_if.sv
hdl/pta_log2_pipe.sv
hdl/pta_pow2_pipe.sv
hdl/pressure_to_altitude_isa_unit.sv
tb/pta_tb_pkg.sv
tb/pressure_to_altitude_isa_unit_test.sv
